// ===== rtl/blvpd_pkg.sv =====
// ----------------------------------------------------------------------------
// blvpd_pkg
// Types and constants shared by the battery low-voltage power derater.
// ----------------------------------------------------------------------------
package blvpd_pkg;

  localparam int VOLTS_W    = 13;
  localparam int SECONDS_W  = 14;
  localparam int LEVEL_W    = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOLTS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VOLTS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_VOLTS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN1_SECONDS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN2_SECONDS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GRACE_SECONDS = 3'd5;

  localparam logic [VOLTS_W-1:0]   MIN_VOLTS_RST     = 13'd2260;
  localparam logic [VOLTS_W-1:0]   START_VOLTS_RST   = 13'd2640;
  localparam logic [VOLTS_W-1:0]   RECOVER_VOLTS_RST = 13'd2400;
  localparam logic [SECONDS_W-1:0] WARN1_SECONDS_RST = 14'd600;
  localparam logic [SECONDS_W-1:0] WARN2_SECONDS_RST = 14'd420;
  localparam logic [SECONDS_W-1:0] GRACE_SECONDS_RST = 14'd120;

  // Division by 5 as multiply by ceil(2^18 / 5), exact over 14 bits.
  localparam logic [15:0] DIV5_RECIP = 16'd52429;
  localparam int          DIV5_SHIFT = 18;

  localparam logic [LEVEL_W-1:0] RESTORE_THROTTLE = 13'd410;
  localparam logic [LEVEL_W-1:0] LEVEL_HALF       = 13'd2048;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL       = 13'd4096;

  localparam int LAMP_RED   = 0;
  localparam int LAMP_GREEN = 1;
  localparam int LAMP_BEEP  = 2;

  typedef enum logic [2:0] {
    MODE_STARTUP   = 3'd0,
    MODE_VOLTCHECK = 3'd1,
    MODE_GOOD      = 3'd2,
    MODE_WARN1     = 3'd3,
    MODE_WARN2     = 3'd4,
    MODE_DEATH     = 3'd5,
    MODE_LOCKOUT   = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    CEIL_ZERO = 2'd0,
    CEIL_HALF = 2'd1,
    CEIL_FULL = 2'd2
  } ceiling_t;

  typedef struct packed {
    logic               tick;
    logic [VOLTS_W-1:0] battery_volts;
    logic [LEVEL_W-1:0] throttle_level;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] drive_level;
    logic               red_lamp;
    logic               green_lamp;
    logic               beeper;
    logic [2:0]         mode_code;
  } out_item_t;

endpackage

// ===== rtl/blvpd_if.sv =====
// ----------------------------------------------------------------------------
// blvpd_if
// Valid/ready channels carrying derater input items and result items.
// ----------------------------------------------------------------------------
interface blvpd_in_if
  import blvpd_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface blvpd_out_if
  import blvpd_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/battery_low_voltage_power_derater.sv =====
// ----------------------------------------------------------------------------
// battery_low_voltage_power_derater
// Clamps the throttle to a battery-dependent power ceiling and runs the
// low-voltage mode machine with its lamp and beeper patterns.
//
// Usage:
//   items   : input channel; each transaction carries tick, battery_volts and
//             throttle_level. A tick advances the mode machine by one step.
//   results : output channel; one transaction per input transaction with
//             drive_level, red_lamp, green_lamp, beeper and mode_code.
//   cfg_*   : register writes, user-bound: only while no transaction is in flight (not enforced).
// Timing:
//   Two register stages (input register, result register); a result is
//   presented in the result register once its input transaction has left the
//   input register. One transaction per cycle is sustained while results.ready
//   stays high; the mode state is updated in the cycle an item leaves the
//   input register, so the next item sees it at once.
// Reset:
//   Mode Startup, all counters zero, zero power, lamps and beeper off,
//   registers at their default values.
// Stall:
//   A stalled result holds the result register; one more transaction is held
//   in the input register, then items.ready drops.
// ----------------------------------------------------------------------------
module battery_low_voltage_power_derater
  import blvpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  blvpd_in_if.sink              items,
  blvpd_out_if.source           results,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [VOLTS_W-1:0]   min_volts;
  logic [VOLTS_W-1:0]   start_volts;
  logic [VOLTS_W-1:0]   recover_volts;
  logic [11:0]          warn1_limit;
  logic [SECONDS_W-1:0] warn2_seconds;
  logic [SECONDS_W-1:0] grace_seconds;
  logic [29:0]          warn1_product;

  logic     s1_valid;
  in_item_t s1_item;
  logic     out_valid;
  out_item_t out_item;
  logic     advance;

  mode_t    mode, mode_next;
  logic [4:0]  early_ticks, early_ticks_next;
  logic [5:0]  phase50, phase50_next;
  logic [3:0]  phase10, phase10_next;
  logic [3:0]  phase12, phase12_next;
  logic [6:0]  good_count, good_count_next;
  logic [4:0]  low_count, low_count_next;
  logic [14:0] stage_timer, stage_timer_next;
  ceiling_t    power_ceiling, power_ceiling_next;
  logic        restore_pending, restore_pending_next;
  logic [2:0]  lamps, lamps_next;

  logic [14:0]        blackout_second;
  logic [14:0]        death_second;
  logic [LEVEL_W-1:0] ceil_level;
  out_item_t          result_next;

  assign warn1_product   = cfg_data * DIV5_RECIP;
  assign blackout_second = {1'b0, warn2_seconds} - 15'd15;
  assign death_second    = {1'b0, warn2_seconds} + {1'b0, grace_seconds};

  always_ff @(posedge clk) begin
    if (rst) begin
      min_volts     <= MIN_VOLTS_RST;
      start_volts   <= START_VOLTS_RST;
      recover_volts <= RECOVER_VOLTS_RST;
      warn1_limit   <= 12'(WARN1_SECONDS_RST / 5);
      warn2_seconds <= WARN2_SECONDS_RST;
      grace_seconds <= GRACE_SECONDS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_VOLTS:     min_volts     <= cfg_data[VOLTS_W-1:0];
        CFG_START_VOLTS:   start_volts   <= cfg_data[VOLTS_W-1:0];
        CFG_RECOVER_VOLTS: recover_volts <= cfg_data[VOLTS_W-1:0];
        CFG_WARN1_SECONDS: warn1_limit   <= warn1_product[DIV5_SHIFT +: 12];
        CFG_WARN2_SECONDS: warn2_seconds <= cfg_data;
        CFG_GRACE_SECONDS: grace_seconds <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance       = s1_valid && (!out_valid || results.ready);
  assign items.ready   = !s1_valid || advance;
  assign results.valid = out_valid;
  assign results.data  = out_item;

  always_comb begin
    mode_next            = mode;
    early_ticks_next     = early_ticks;
    phase50_next         = phase50;
    phase10_next         = phase10;
    phase12_next         = phase12;
    good_count_next      = good_count;
    low_count_next       = low_count;
    stage_timer_next     = stage_timer;
    power_ceiling_next   = power_ceiling;
    restore_pending_next = restore_pending;
    lamps_next           = lamps;

    if (s1_item.tick) begin
      if (early_ticks < 5'd16) early_ticks_next = early_ticks + 5'd1;
      phase50_next = (phase50 == 6'd49) ? 6'd0 : phase50 + 6'd1;
      phase10_next = (phase10 == 4'd9)  ? 4'd0 : phase10 + 4'd1;
      phase12_next = (phase12 == 4'd11) ? 4'd0 : phase12 + 4'd1;

      case (mode)
        MODE_STARTUP: begin
          if (early_ticks_next < 5'd2) begin
            lamps_next[LAMP_BEEP]  = 1'b0;
            lamps_next[LAMP_RED]   = 1'b1;
            lamps_next[LAMP_GREEN] = 1'b0;
          end
          if (early_ticks_next > 5'd5) mode_next = MODE_VOLTCHECK;
        end
        MODE_VOLTCHECK: begin
          if (early_ticks_next > 5'd15) begin
            if (good_count > 7'd6) begin
              good_count_next        = '0;
              lamps_next[LAMP_RED]   = 1'b0;
              lamps_next[LAMP_GREEN] = 1'b1;
              power_ceiling_next     = CEIL_FULL;
              mode_next              = MODE_GOOD;
            end else begin
              mode_next = MODE_DEATH;
            end
          end else if (s1_item.battery_volts > start_volts) begin
            if (good_count < 7'd127) good_count_next = good_count + 7'd1;
            lamps_next[LAMP_RED]   = 1'b0;
            lamps_next[LAMP_GREEN] = 1'b1;
          end else begin
            lamps_next[LAMP_RED]   = 1'b1;
            lamps_next[LAMP_GREEN] = 1'b0;
          end
        end
        MODE_GOOD: begin
          if (s1_item.battery_volts > min_volts) begin
            low_count_next = '0;
          end else begin
            if (low_count < 5'd31) low_count_next = low_count + 5'd1;
            if (low_count_next > 5'd20) begin
              lamps_next[LAMP_GREEN] = 1'b0;
              lamps_next[LAMP_RED]   = 1'b1;
              low_count_next         = '0;
              stage_timer_next       = '0;
              mode_next              = MODE_WARN1;
            end
          end
        end
        MODE_WARN1: begin
          if (s1_item.battery_volts > recover_volts) begin
            if (good_count < 7'd127) good_count_next = good_count + 7'd1;
            if (good_count_next > 7'd100) begin
              lamps_next[LAMP_RED]   = 1'b0;
              lamps_next[LAMP_BEEP]  = 1'b0;
              lamps_next[LAMP_GREEN] = 1'b1;
              good_count_next        = '0;
              mode_next              = MODE_GOOD;
            end
          end else begin
            good_count_next = '0;
          end
          if (phase10_next == 4'd0) begin
            lamps_next[LAMP_RED] = 1'b0;
          end else if (phase10_next == 4'd5) begin
            lamps_next[LAMP_RED] = 1'b1;
          end else if (phase50_next == 6'd1) begin
            lamps_next[LAMP_BEEP] = 1'b1;
          end else if (phase50_next == 6'd41) begin
            lamps_next[LAMP_BEEP] = 1'b0;
          end else if (phase50_next == 6'd12) begin
            if (stage_timer < 15'd32767) stage_timer_next = stage_timer + 15'd1;
            if (stage_timer_next > {3'd0, warn1_limit}) begin
              lamps_next[LAMP_RED] = 1'b1;
              power_ceiling_next   = CEIL_HALF;
              stage_timer_next     = '0;
              mode_next            = MODE_WARN2;
            end
          end
        end
        MODE_WARN2: begin
          if (phase10_next == 4'd0) begin
            if (stage_timer < 15'd32767) stage_timer_next = stage_timer + 15'd1;
            if (warn2_seconds >= 14'd15 && stage_timer_next == blackout_second)
              power_ceiling_next = CEIL_ZERO;
            if (stage_timer_next == {1'b0, warn2_seconds}) begin
              restore_pending_next = 1'b1;
              power_ceiling_next   = CEIL_HALF;
            end
            if (stage_timer_next > death_second) begin
              stage_timer_next   = '0;
              power_ceiling_next = CEIL_ZERO;
              mode_next          = MODE_DEATH;
            end
          end else if (phase10_next == 4'd1) begin
            lamps_next[LAMP_BEEP] = 1'b1;
          end else if (phase10_next == 4'd8) begin
            lamps_next[LAMP_BEEP] = 1'b0;
          end
        end
        MODE_DEATH: begin
          power_ceiling_next     = CEIL_ZERO;
          lamps_next[LAMP_BEEP]  = 1'b1;
          lamps_next[LAMP_RED]   = 1'b0;
          lamps_next[LAMP_GREEN] = 1'b0;
          mode_next              = MODE_LOCKOUT;
        end
        MODE_LOCKOUT: begin
          if (phase12_next < 4'd6) lamps_next[LAMP_BEEP] = ~phase12_next[0];
        end
        default: ;
      endcase
    end

    if (restore_pending_next && s1_item.throttle_level < RESTORE_THROTTLE) begin
      restore_pending_next = 1'b0;
      power_ceiling_next   = CEIL_HALF;
    end

    case (power_ceiling_next)
      CEIL_ZERO: ceil_level = '0;
      CEIL_HALF: ceil_level = LEVEL_HALF;
      default:   ceil_level = LEVEL_FULL;
    endcase

    result_next.drive_level = (s1_item.throttle_level > ceil_level) ? ceil_level
                                                                     : s1_item.throttle_level;
    result_next.red_lamp    = lamps_next[LAMP_RED];
    result_next.green_lamp  = lamps_next[LAMP_GREEN];
    result_next.beeper      = lamps_next[LAMP_BEEP];
    result_next.mode_code   = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
      mode            <= MODE_STARTUP;
      early_ticks     <= '0;
      phase50         <= '0;
      phase10         <= '0;
      phase12         <= '0;
      good_count      <= '0;
      low_count       <= '0;
      stage_timer     <= '0;
      power_ceiling   <= CEIL_ZERO;
      restore_pending <= 1'b0;
      lamps           <= '0;
    end else begin
      if (items.ready) s1_valid <= items.valid;
      if (advance) begin
        out_valid       <= 1'b1;
        mode            <= mode_next;
        early_ticks     <= early_ticks_next;
        phase50         <= phase50_next;
        phase10         <= phase10_next;
        phase12         <= phase12_next;
        good_count      <= good_count_next;
        low_count       <= low_count_next;
        stage_timer     <= stage_timer_next;
        power_ceiling   <= power_ceiling_next;
        restore_pending <= restore_pending_next;
        lamps           <= lamps_next;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) s1_item <= items.data;
    if (advance) out_item <= result_next;
  end

endmodule
